// ===== rtl/nrm_pkg.sv =====
`timescale 1ns / 1ps
package nrm_pkg;
    localparam int MAX_STATES_DEF = 64;
    localparam int SLOT_W = 6;
    localparam int SYM_W = 8;
    localparam int ENTRY_W = 22;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_ANY     = 2'd1;
    localparam logic [1:0] KIND_BRANCH  = 2'd2;
    localparam logic [1:0] KIND_MATCH   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_CL_RD,
        ST_CL_CHK,
        ST_REPORT
    } t_state;
endpackage

// ===== rtl/nrm_ram.sv =====
`timescale 1ns / 1ps
module nrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/nfa_regex_matcher_unit.sv =====
`timescale 1ns / 1ps
// Thompson NFA matcher. Load the table with op 0, begin with op 1, feed characters with
// op 2. busy is high while a transaction is worked on; one result strobe (o_valid) follows
// each accepted transaction and cannot be held off. A load and op 3 go straight to the
// report; a start runs a closure from the start slot. A character scans the active set slot
// by slot, and each active slot that matches can start a closure pass over its successor
// that visits entries until nothing is pending; all table reads go through the single
// registered port of the table RAM. Each result reports the set after the transaction.
// Active, match and closure work masks live in flip-flops.
module nfa_regex_matcher_unit
    import nrm_pkg::*;
#(
    parameter int MAX_STATES = MAX_STATES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_op,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [1:0]        i_entry_kind,
    input  logic [SYM_W-1:0]  i_entry_symbol,
    input  logic [SLOT_W-1:0] i_entry_next,
    input  logic [SLOT_W-1:0] i_entry_next_alt,
    input  logic [SLOT_W-1:0] i_start_slot,
    input  logic [SYM_W-1:0]  i_char_in,
    output logic              o_valid,
    output logic              o_set_empty,
    output logic              o_accepting
);
    localparam int AW = $clog2(MAX_STATES);
    localparam int CW = $clog2(MAX_STATES + 1);

    t_state r_state, n_state;
    logic [MAX_STATES-1:0] r_active, n_active;
    logic [MAX_STATES-1:0] r_next, n_next;
    logic [MAX_STATES-1:0] r_mark, n_mark;
    logic [MAX_STATES-1:0] r_pend, n_pend;
    logic [MAX_STATES-1:0] r_ismatch, n_ismatch;
    logic [CW-1:0] r_scan, n_scan;
    logic [AW-1:0] r_cur, n_cur;
    logic [SYM_W-1:0] r_ch, n_ch;
    logic r_is_char, n_is_char;
    logic r_valid, n_valid;
    logic r_empty, r_acc;

    logic we;
    logic [AW-1:0] raddr, waddr;
    logic [ENTRY_W-1:0] rdata, wdata;
    logic [1:0] rd_kind;
    logic [SYM_W-1:0] rd_sym;
    logic [SLOT_W-1:0] rd_next, rd_alt;

    nrm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_STATES)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign {rd_kind, rd_sym, rd_next, rd_alt} = rdata;
    assign waddr = AW'(i_entry_index);
    assign wdata = {i_entry_kind, i_entry_symbol, i_entry_next, i_entry_next_alt};
    assign busy = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_set_empty = r_empty;
    assign o_accepting = r_acc;

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_active <= '0;
            r_pend <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_active <= n_active;
            r_pend <= n_pend;
            r_valid <= n_valid;
        end
        r_next <= n_next;
        r_mark <= n_mark;
        r_ismatch <= n_ismatch;
        r_scan <= n_scan;
        r_cur <= n_cur;
        r_ch <= n_ch;
        r_is_char <= n_is_char;
        if (r_state == ST_REPORT) begin
            r_empty <= (r_active == '0);
            r_acc <= ((r_active & r_ismatch) != '0);
        end
    end

    // sequencer: loads, start closures, and the active-set scan with a closure over a pending mask
    always_comb begin
        logic in0, in1;
        logic [AW-1:0] s0, s1, pick;
        n_state = r_state;
        n_active = r_active;
        n_next = r_next;
        n_mark = r_mark;
        n_pend = r_pend;
        n_ismatch = r_ismatch;
        n_scan = r_scan;
        n_cur = r_cur;
        n_ch = r_ch;
        n_is_char = r_is_char;
        n_valid = 1'b0;
        we = 1'b0;
        raddr = r_cur;
        in0 = ({{(32-SLOT_W){1'b0}}, rd_next} < MAX_STATES);
        in1 = ({{(32-SLOT_W){1'b0}}, rd_alt} < MAX_STATES);
        s0 = AW'(rd_next);
        s1 = AW'(rd_alt);
        // lowest pending slot
        pick = '0;
        for (int i = MAX_STATES - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                pick = AW'(i);
            end
        end
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_ch = i_char_in;
                    n_mark = '0;
                    n_pend = '0;
                    n_state = ST_REPORT;
                    case (i_op)
                        OP_LOAD: begin
                            we = ({{(32-SLOT_W){1'b0}}, i_entry_index} < MAX_STATES);
                            // keep the match mask in step with the table
                            if (we) begin
                                n_ismatch[waddr] = (i_entry_kind == KIND_MATCH);
                            end
                        end
                        OP_START: begin
                            n_is_char = 1'b0;
                            n_next = '0;
                            n_ismatch = '0;
                            if ({{(32-SLOT_W){1'b0}}, i_start_slot} < MAX_STATES) begin
                                n_pend[AW'(i_start_slot)] = 1'b1;
                                n_mark[AW'(i_start_slot)] = 1'b1;
                                n_state = ST_CL_RD;
                            end else begin
                                n_active = '0;
                            end
                        end
                        OP_CHAR: begin
                            n_is_char = 1'b1;
                            n_next = '0;
                            n_ismatch = '0;
                            n_scan = '0;
                            n_state = ST_SCAN_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN_RD: begin
                if (r_scan == CW'(MAX_STATES)) begin
                    n_active = r_next;
                    n_state = ST_REPORT;
                end else if (r_active[r_scan[AW-1:0]]) begin
                    raddr = r_scan[AW-1:0];
                    n_state = ST_SCAN_CHK;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            ST_SCAN_CHK: begin
                n_scan = r_scan + 1'b1;
                n_state = ST_SCAN_RD;
                if ((rd_kind == KIND_ANY || (rd_kind == KIND_LITERAL && rd_sym == r_ch))
                    && in0 && !r_mark[s0]) begin
                    n_mark[s0] = 1'b1;
                    n_pend[s0] = 1'b1;
                    n_state = ST_CL_RD;
                end
            end
            ST_CL_RD: begin
                if (r_pend == '0) begin
                    if (r_is_char) begin
                        n_state = ST_SCAN_RD;
                    end else begin
                        n_active = r_next;
                        n_state = ST_REPORT;
                    end
                end else begin
                    raddr = pick;
                    n_cur = pick;
                    n_pend[pick] = 1'b0;
                    n_state = ST_CL_CHK;
                end
            end
            ST_CL_CHK: begin
                n_state = ST_CL_RD;
                if (rd_kind == KIND_BRANCH) begin
                    if (in0 && !r_mark[s0]) begin
                        n_pend[s0] = 1'b1;
                        n_mark[s0] = 1'b1;
                    end
                    if (in1 && !n_mark[s1]) begin
                        n_pend[s1] = 1'b1;
                        n_mark[s1] = 1'b1;
                    end
                end else begin
                    n_next[r_cur] = 1'b1;
                    n_ismatch[r_cur] = (rd_kind == KIND_MATCH);
                end
            end
            ST_REPORT: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // checks
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT) |=> (o_valid && !busy))
        else $error("result strobe missing");
    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_REPORT))
        else $error("stray result");
    a_pend_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_mark) == '0)
        else $error("pending slot without visit mark");
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_set_empty == (r_active == '0)))
        else $error("empty flag mismatch");
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import nrm_pkg::*;

    localparam int NSLOT = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 400;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct {
        logic [1:0] op;
        logic [5:0] idx;
        logic [1:0] kind;
        logic [7:0] sym;
        logic [5:0] nxt;
        logic [5:0] alt;
        logic [5:0] sslot;
        logic [7:0] ch;
    } t_nfa_txn;

    typedef struct {
        logic empty;
        logic accept;
    } t_set_flags;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] op = '0;
    logic [5:0] entry_index = '0;
    logic [1:0] entry_kind = '0;
    logic [7:0] entry_symbol = '0;
    logic [5:0] entry_next = '0;
    logic [5:0] entry_next_alt = '0;
    logic [5:0] start_slot = '0;
    logic [7:0] char_in = '0;
    logic res_valid;
    logic res_empty;
    logic res_accepting;

    t_nfa_txn pending_txns[$];
    t_set_flags expected_flags[$];
    int n_errors = 0;
    int n_accepted = 0;
    int n_cycles = 0;

    // shadow NFA state
    logic [1:0] shadow_kind[NSLOT];
    logic [7:0] shadow_sym[NSLOT];
    logic [5:0] shadow_next[NSLOT];
    logic [5:0] shadow_alt[NSLOT];
    logic [NSLOT-1:0] live_set = '0;
    logic [NSLOT-1:0] visit_marks;

    nfa_regex_matcher_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_op(op), .i_entry_index(entry_index), .i_entry_kind(entry_kind),
        .i_entry_symbol(entry_symbol), .i_entry_next(entry_next),
        .i_entry_next_alt(entry_next_alt), .i_start_slot(start_slot),
        .i_char_in(char_in), .o_valid(res_valid), .o_set_empty(res_empty),
        .o_accepting(res_accepting)
    );

    always #5 clk = ~clk;

    // epsilon closure of one slot into dst; visit marks persist per pass
    task automatic close_slot(input logic [5:0] slot, inout logic [NSLOT-1:0] dst);
        logic [5:0] work[$];
        logic [5:0] s;
        if (!visit_marks[slot]) begin
            visit_marks[slot] = 1'b1;
            work.push_back(slot);
        end
        while (work.size() > 0) begin
            s = work.pop_back();
            if (shadow_kind[s] == KIND_BRANCH) begin
                if (!visit_marks[shadow_next[s]]) begin
                    visit_marks[shadow_next[s]] = 1'b1;
                    work.push_back(shadow_next[s]);
                end
                if (!visit_marks[shadow_alt[s]]) begin
                    visit_marks[shadow_alt[s]] = 1'b1;
                    work.push_back(shadow_alt[s]);
                end
            end else begin
                dst[s] = 1'b1;
            end
        end
    endtask

    // advance the shadow NFA by one transaction and queue the flags it reports
    task automatic step_nfa(input t_nfa_txn t);
        logic [NSLOT-1:0] nset;
        t_set_flags f;
        nset = '0;
        visit_marks = '0;
        case (t.op)
            OP_LOAD: begin
                shadow_kind[t.idx] = t.kind;
                shadow_sym[t.idx] = t.sym;
                shadow_next[t.idx] = t.nxt;
                shadow_alt[t.idx] = t.alt;
            end
            OP_START: begin
                close_slot(t.sslot, nset);
                live_set = nset;
            end
            OP_CHAR: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (live_set[i] && (shadow_kind[i] == KIND_ANY ||
                        (shadow_kind[i] == KIND_LITERAL && shadow_sym[i] == t.ch)))
                        close_slot(shadow_next[i], nset);
                end
                live_set = nset;
            end
            default: ;
        endcase
        f.empty = (live_set == '0);
        f.accept = 1'b0;
        for (int i = 0; i < NSLOT; i++)
            if (live_set[i] && shadow_kind[i] == KIND_MATCH) f.accept = 1'b1;
        expected_flags.push_back(f);
    endtask

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // stimulus builders
    function automatic t_nfa_txn noise_txn();
        t_nfa_txn t;
        t.op = 2'($urandom_range(0, 3));
        t.idx = 6'($urandom);
        t.kind = 2'($urandom);
        t.sym = 8'($urandom);
        t.nxt = 6'($urandom);
        t.alt = 6'($urandom);
        t.sslot = 6'($urandom);
        t.ch = 8'($urandom);
        return t;
    endfunction

    task automatic add_load(input int idx, input logic [1:0] kind, input int sym,
                            input int nxt, input int alt);
        t_nfa_txn t;
        t = noise_txn();
        t.op = OP_LOAD;
        t.idx = 6'(idx);
        t.kind = kind;
        t.sym = 8'(sym);
        t.nxt = 6'(nxt);
        t.alt = 6'(alt);
        pending_txns.push_back(t);
    endtask

    task automatic add_start(input int slot);
        t_nfa_txn t;
        t = noise_txn();
        t.op = OP_START;
        t.sslot = 6'(slot);
        pending_txns.push_back(t);
    endtask

    task automatic add_char(input int c);
        t_nfa_txn t;
        t = noise_txn();
        t.op = OP_CHAR;
        t.ch = 8'(c);
        pending_txns.push_back(t);
    endtask

    function automatic int pick_symbol();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
        return 97 + $urandom_range(0, 3);
    endfunction

    // stimulus
    initial begin
        t_nfa_txn t;
        int base, len, k, slot;
        logic [1:0] kd;

        // character before any start, unused opcode on an empty set
        add_char(8'h00);
        t = noise_txn();
        t.op = OP_NOP;
        pending_txns.push_back(t);
        // tiny machine at the extreme slots and symbols
        add_load(63, KIND_MATCH, 8'hFF, 63, 63);
        add_load(0, KIND_LITERAL, 8'hFF, 63, 0);
        add_start(0);
        add_char(8'hFE);
        add_start(0);
        add_char(8'hFF);
        t.op = OP_NOP;
        pending_txns.push_back(t);
        add_char(8'h00);
        // branch cycle back onto itself, then any-character loop
        add_load(1, KIND_BRANCH, 0, 1, 2);
        add_load(2, KIND_ANY, 8'h00, 3, 0);
        add_load(3, KIND_BRANCH, 0, 2, 63);
        add_start(1);
        add_char(8'h00);
        add_char(8'hFF);
        add_start(63);
        add_char(8'h41);
        add_load(62, KIND_BRANCH, 0, 62, 62);
        add_start(62);

        // fill every slot so that no later read hits an unwritten entry
        for (int i = 4; i < 62; i++)
            add_load(i, 2'($urandom), $urandom, $urandom_range(0, 63), $urandom_range(0, 63));

        // random programs over a small alphabet, with some noise
        while (pending_txns.size() < 1630) begin
            if ($urandom_range(0, 9) == 0) begin
                t = noise_txn();
                pending_txns.push_back(t);
                continue;
            end
            len = $urandom_range(3, 14);
            base = $urandom_range(0, 63 - len);
            for (int i = 0; i < len; i++) begin
                slot = base + i;
                k = $urandom_range(0, 99);
                if (i == len - 1) kd = KIND_MATCH;
                else if (k < 50) kd = KIND_LITERAL;
                else if (k < 60) kd = KIND_ANY;
                else if (k < 85) kd = KIND_BRANCH;
                else kd = KIND_MATCH;
                add_load(slot, kd, pick_symbol(), base + $urandom_range(0, len - 1),
                         base + $urandom_range(0, len - 1));
            end
            add_start(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : base);
            k = $urandom_range(3, 25);
            for (int i = 0; i < k; i++) add_char(pick_symbol());
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // drain
        while (pending_txns.size() > 0 || start || expected_flags.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // driver
    t_nfa_txn cur_txn;
    logic drv_idle;
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                cur_txn.op = op;
                cur_txn.idx = entry_index;
                cur_txn.kind = entry_kind;
                cur_txn.sym = entry_symbol;
                cur_txn.nxt = entry_next;
                cur_txn.alt = entry_next_alt;
                cur_txn.sslot = start_slot;
                cur_txn.ch = char_in;
                step_nfa(cur_txn);
                n_accepted++;
            end
            if (!(start && busy)) begin
                drv_idle = (n_accepted > 700 && n_accepted < 1000) ? 1'b0
                           : ($urandom_range(0, 99) < 27);
                if (pending_txns.size() > 0 && !drv_idle) begin
                    cur_txn = pending_txns.pop_front();
                    op <= cur_txn.op;
                    entry_index <= cur_txn.idx;
                    entry_kind <= cur_txn.kind;
                    entry_symbol <= cur_txn.sym;
                    entry_next <= cur_txn.nxt;
                    entry_next_alt <= cur_txn.alt;
                    start_slot <= cur_txn.sslot;
                    char_in <= cur_txn.ch;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    t_set_flags exp_f;
    always @(posedge clk) begin
        if (rst_n && res_valid) begin
            if (expected_flags.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                exp_f = expected_flags.pop_front();
                if (res_empty !== exp_f.empty)
                    report_mismatch($sformatf("set_empty %b, expected %b",
                                              res_empty, exp_f.empty));
                if (res_accepting !== exp_f.accept)
                    report_mismatch($sformatf("accepting %b, expected %b",
                                              res_accepting, exp_f.accept));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end
endmodule
